@@ sv/fat_dew_pkg.sv @@
// shared types and constants of the fat directory entry walker
`default_nettype none
package fat_dew_pkg;

  localparam int unsigned SlotBytes = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned ChunkW = 64;
  localparam int unsigned UnitsPerMember = 13;
  localparam int unsigned ScanW = 9;
  localparam int unsigned RunW = 5;
  localparam int unsigned LongNameMax = 255;

  localparam logic [7:0] B0Terminator = 8'h00;
  localparam logic [7:0] B0Deleted = 8'hE5;
  localparam logic [7:0] B0Kanji = 8'h05;
  localparam logic [7:0] OrdMask = 8'h3F;
  localparam logic [7:0] LnAttr = 8'h0F;
  localparam logic [7:0] LastFlag = 8'h40;
  localparam logic [7:0] VolBit = 8'h08;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDot = 8'h2E;
  localparam logic [15:0] UnitPad = 16'hFFFF;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take_byte;
    logic restart;
    logic set_done;
    logic pos_clear;
    logic run_clear;
    logic run_start;
    logic slot_inc;
    logic wr_init;
    logic wr_unit;
    logic scan_init;
    logic scan_adv;
    logic long_init;
    logic short_init;
    logic acc_unit;
    logic load_end;
    logic load_long;
    logic load_short;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic b0_zero;
    logic b0_deleted;
    logic is_ln;
    logic ord_bad;
    logic last_flag;
    logic chk_match;
    logic run_active;
    logic is_vol;
    logic sum_match;
    logic done;
    logic pos_last;
    logic wr_last;
    logic at_max;
    logic addr_at_top;
    logic addr_zero;
    logic unit_term;
    logic acc_full;
    logic long_last;
    logic short_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ sv/fat_dew_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none
module fat_dew_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 260
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ sv/fat_dew_datapath.sv @@
// slot buffer, run tracking, name store and result register
`default_nettype none
module fat_dew_datapath #(
  parameter int unsigned MAX_NAME_MEMBERS = 20,
  parameter int unsigned SLOT_INDEX_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fat_dew_pkg::cmd_t     cmd_i,
  output fat_dew_pkg::status_t       status_o,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [63:0]                name_chunk_o,
  output logic [2:0]                 chunk_units_o,
  output logic                       last_of_entry_o,
  output logic                       end_of_directory_o,
  output logic [15:0]                entry_slot_o,
  output logic [15:0]                name_start_slot_o,
  output logic [7:0]                 attributes_o,
  output logic [31:0]                first_cluster_o,
  output logic [31:0]                file_size_o,
  output logic                       used_long_name_o
);

  localparam int unsigned StoreDepth = MAX_NAME_MEMBERS * fat_dew_pkg::UnitsPerMember;
  localparam int unsigned RamAw = $clog2(StoreDepth);
  localparam int unsigned MemIdxW = (MAX_NAME_MEMBERS > 1) ? $clog2(MAX_NAME_MEMBERS) : 1;
  localparam int unsigned SW = fat_dew_pkg::ScanW;

  // slot buffer and walk state
  logic [7:0]                 slot_q [fat_dew_pkg::SlotBytes];
  logic [4:0]                 pos_q;
  logic [7:0]                 sum_q;
  logic [SLOT_INDEX_BITS-1:0] cnt_q;
  logic                       done_q;
  logic [4:0]                 run_top_q;
  logic [7:0]                 chk_q;
  logic [SLOT_INDEX_BITS-1:0] first_q;
  logic [MAX_NAME_MEMBERS-1:0] mvalid_q;
  // name store write side
  logic [SW-1:0]              wr_addr_q;
  logic [3:0]                 wr_i_q;
  logic [4:0]                 wmem_q;
  // name store read side
  logic [SW-1:0]              addr_q;
  logic [4:0]                 mem_q;
  logic [3:0]                 uim_q;
  logic [SW-1:0]              n_q;
  logic [2:0]                 uc_q;
  logic [63:0]                chunk_q;
  logic                       use_long_q;
  logic [1:0]                 k_q;
  // result register
  logic                       out_valid_q;

  logic [4:0]  pos_eff;
  logic [7:0]  sum_base;
  logic [5:0]  ord;
  logic [15:0] ln_units [fat_dew_pkg::UnitsPerMember];
  logic [15:0] ram_rdata;
  logic [15:0] unit_val;
  logic [SW-1:0] max_units;
  logic [3:0]  p83;
  logic [1:0]  e83;
  logic        has_ext;
  logic [3:0]  n83;
  logic [15:0] u83 [12];
  logic [1:0]  cnt83;
  logic [3:0]  rem83;
  logic [63:0] short_chunk;
  logic [2:0]  short_units;
  logic        out_free;
  logic        ram_we;

  assign pos_eff = cmd_i.restart ? 5'd0 : pos_q;
  assign sum_base = (pos_eff == 5'd0) ? 8'h00 : sum_q;
  assign ord = slot_q[0][5:0];
  assign max_units = SW'(run_top_q * fat_dew_pkg::UnitsPerMember);
  assign unit_val = mvalid_q[mem_q[MemIdxW-1:0]] ? ram_rdata : 16'h0000;
  assign out_free = !out_valid_q || out_ready_i;
  assign ram_we = cmd_i.wr_unit;

  // name units of a long-name slot at their fixed offsets
  always_comb begin
    for (int i = 0; i < fat_dew_pkg::UnitsPerMember; i++) begin
      int off;
      off = (i < 5) ? (1 + i * 2) : ((i < 11) ? (14 + (i - 5) * 2) : (28 + (i - 11) * 2));
      ln_units[i] = {slot_q[off + 1], slot_q[off]};
    end
  end

  // rendered 8.3 name
  always_comb begin
    logic stop;
    p83 = 4'd0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stop && slot_q[i] != fat_dew_pkg::CharSpace) begin
        p83 = p83 + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
    e83 = 2'd0;
    stop = 1'b0;
    for (int i = 8; i < 11; i++) begin
      if (!stop && slot_q[i] != fat_dew_pkg::CharSpace) begin
        e83 = e83 + 2'd1;
      end else begin
        stop = 1'b1;
      end
    end
    has_ext = slot_q[8] != fat_dew_pkg::CharSpace;
    n83 = has_ext ? (p83 + 4'd1 + 4'(e83)) : p83;
    for (int j = 0; j < 12; j++) begin
      u83[j] = 16'h0000;
      if (4'(j) < p83) begin
        if (j == 0 && slot_q[0] == fat_dew_pkg::B0Kanji) begin
          u83[j] = {8'h00, fat_dew_pkg::B0Deleted};
        end else begin
          u83[j] = {8'h00, slot_q[j]};
        end
      end else if (has_ext && 4'(j) == p83) begin
        u83[j] = {8'h00, fat_dew_pkg::CharDot};
      end else if (has_ext && 4'(j) < n83) begin
        u83[j] = {8'h00, slot_q[8 + 3'(4'(j) - p83 - 4'd1)]};
      end
    end
    cnt83 = (n83 == 4'd0) ? 2'd0 : 2'((n83 - 4'd1) >> 2);
    rem83 = n83 - {k_q, 2'b00};
    short_units = (rem83 > 4'd4) ? 3'd4 : rem83[2:0];
    for (int u = 0; u < 4; u++) begin
      short_chunk[u * 16 +: 16] = (3'(u) < short_units) ? u83[{k_q, 2'(u)}] : 16'h0000;
    end
  end

  // status toward the controller
  always_comb begin
    status_o.b0_zero = slot_q[0] == fat_dew_pkg::B0Terminator;
    status_o.b0_deleted = slot_q[0] == fat_dew_pkg::B0Deleted;
    status_o.is_ln = (slot_q[11] & fat_dew_pkg::OrdMask) == fat_dew_pkg::LnAttr;
    status_o.ord_bad = (ord == 6'd0) || (ord > 6'(MAX_NAME_MEMBERS));
    status_o.last_flag = (slot_q[0] & fat_dew_pkg::LastFlag) != 8'h00;
    status_o.chk_match = slot_q[13] == chk_q;
    status_o.run_active = run_top_q != 5'd0;
    status_o.is_vol = (slot_q[11] & fat_dew_pkg::VolBit) != 8'h00;
    status_o.sum_match = sum_q == chk_q;
    status_o.done = done_q;
    status_o.pos_last = pos_q == 5'd31;
    status_o.wr_last = wr_i_q == 4'(fat_dew_pkg::UnitsPerMember - 1);
    status_o.at_max = addr_q == max_units;
    status_o.addr_at_top = addr_q == SW'(fat_dew_pkg::LongNameMax);
    status_o.addr_zero = addr_q == '0;
    status_o.unit_term = (unit_val == 16'h0000) || (unit_val == fat_dew_pkg::UnitPad);
    status_o.acc_full = (addr_q + SW'(1) == n_q) || (uc_q == 3'd3);
    status_o.long_last = addr_q == n_q;
    status_o.short_last = k_q == cnt83;
    status_o.out_free = out_free;
  end

  // slot bytes carry no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      slot_q[pos_eff] <= data_byte_i;
    end
  end

  // walk and run control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
      done_q <= 1'b0;
      run_top_q <= '0;
      chk_q <= '0;
      first_q <= '0;
      mvalid_q <= '0;
    end else begin
      if (cmd_i.restart) begin
        cnt_q <= '0;
        pos_q <= '0;
      end
      if (cmd_i.set_done) begin
        done_q <= 1'b1;
      end else if (cmd_i.restart) begin
        done_q <= 1'b0;
      end
      if (cmd_i.pos_clear) begin
        pos_q <= '0;
      end
      if (cmd_i.take_byte) begin
        pos_q <= pos_eff + 5'd1;
        if (pos_eff <= 5'd10) begin
          sum_q <= {sum_base[0], sum_base[7:1]} + data_byte_i;
        end
      end
      if (cmd_i.slot_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.run_clear) begin
        run_top_q <= '0;
      end else if (cmd_i.run_start) begin
        run_top_q <= ord[4:0];
        chk_q <= slot_q[13];
        first_q <= cnt_q;
        mvalid_q <= '0;
      end
      if (cmd_i.wr_unit && status_o.wr_last) begin
        mvalid_q[wmem_q[MemIdxW-1:0]] <= 1'b1;
      end
    end
  end

  // name store counters and chunk assembly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_addr_q <= '0;
      wr_i_q <= '0;
      wmem_q <= '0;
      addr_q <= '0;
      mem_q <= '0;
      uim_q <= '0;
      n_q <= '0;
      uc_q <= '0;
      chunk_q <= '0;
      use_long_q <= 1'b0;
      k_q <= '0;
    end else begin
      if (cmd_i.wr_init) begin
        wr_addr_q <= SW'((ord - 6'd1) * fat_dew_pkg::UnitsPerMember);
        wr_i_q <= '0;
        wmem_q <= 5'(ord - 6'd1);
      end else if (cmd_i.wr_unit) begin
        wr_addr_q <= wr_addr_q + SW'(1);
        wr_i_q <= wr_i_q + 4'd1;
      end
      if (cmd_i.scan_init || cmd_i.long_init) begin
        addr_q <= '0;
        mem_q <= '0;
        uim_q <= '0;
        uc_q <= '0;
        chunk_q <= '0;
      end else if (cmd_i.scan_adv || cmd_i.acc_unit) begin
        addr_q <= addr_q + SW'(1);
        if (uim_q == 4'(fat_dew_pkg::UnitsPerMember - 1)) begin
          uim_q <= '0;
          mem_q <= mem_q + 5'd1;
        end else begin
          uim_q <= uim_q + 4'd1;
        end
      end
      if (cmd_i.acc_unit) begin
        chunk_q[uc_q[1:0] * 16 +: 16] <= unit_val;
        uc_q <= uc_q + 3'd1;
      end else if (cmd_i.load_long) begin
        chunk_q <= '0;
        uc_q <= '0;
      end
      if (cmd_i.long_init) begin
        n_q <= addr_q;
        use_long_q <= 1'b1;
      end else if (cmd_i.scan_init || cmd_i.short_init) begin
        use_long_q <= 1'b0;
      end
      if (cmd_i.short_init) begin
        k_q <= '0;
      end else if (cmd_i.load_short) begin
        k_q <= k_q + 2'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_end || cmd_i.load_long || cmd_i.load_short) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_end || cmd_i.load_long || cmd_i.load_short) begin
      logic fin;
      fin = (cmd_i.load_long && status_o.long_last) ||
            (cmd_i.load_short && status_o.short_last);
      name_chunk_o <= cmd_i.load_long ? chunk_q : (cmd_i.load_short ? short_chunk : '0);
      chunk_units_o <= cmd_i.load_long ? uc_q : (cmd_i.load_short ? short_units : 3'd0);
      last_of_entry_o <= fin || cmd_i.load_end;
      end_of_directory_o <= cmd_i.load_end;
      entry_slot_o <= fin ? 16'(cnt_q) : 16'h0000;
      name_start_slot_o <= fin ? (use_long_q ? 16'(first_q) : 16'(cnt_q)) : 16'h0000;
      attributes_o <= fin ? slot_q[11] : 8'h00;
      first_cluster_o <= fin ? {slot_q[21], slot_q[20], slot_q[27], slot_q[26]} : 32'h0;
      file_size_o <= fin ? {slot_q[31], slot_q[30], slot_q[29], slot_q[28]} : 32'h0;
      used_long_name_o <= fin && use_long_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // long-name unit store
  fat_dew_ram #(
    .WIDTH(fat_dew_pkg::UnitW),
    .DEPTH(StoreDepth)
  ) u_name_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_addr_q[RamAw-1:0]),
    .wdata_i(ln_units[wr_i_q]),
    .raddr_i(addr_q[RamAw-1:0]),
    .rdata_o(ram_rdata)
  );

endmodule
`default_nettype wire

@@ sv/fat_dew_ctrl.sv @@
// walker controller state machine
`default_nettype none
module fat_dew_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 directory_start_i,
  input  wire logic                 chain_end_i,
  output logic                      in_ready_o,
  input  wire fat_dew_pkg::status_t status_i,
  output fat_dew_pkg::cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StProc, StWrite, StScanWait, StScanChk,
    StLongWait, StLongAcc, StLongLoad, StShortLoad, StEnd
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == StIdle;

  // next state and datapath commands
  always_comb begin
    logic fin_scan;
    state_d = state_q;
    cmd_o = '0;
    fin_scan = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (directory_start_i) begin
            cmd_o.restart = 1'b1;
            cmd_o.run_clear = 1'b1;
          end
          if (!(status_i.done && !directory_start_i)) begin
            if (chain_end_i) begin
              cmd_o.set_done = 1'b1;
              cmd_o.run_clear = 1'b1;
              cmd_o.pos_clear = 1'b1;
              state_d = StEnd;
            end else begin
              cmd_o.take_byte = 1'b1;
              if (status_i.pos_last && !directory_start_i) begin
                state_d = StProc;
              end
            end
          end
        end
      end
      StProc: begin
        priority if (status_i.b0_zero) begin
          cmd_o.set_done = 1'b1;
          cmd_o.run_clear = 1'b1;
          state_d = StEnd;
        end else if (status_i.b0_deleted) begin
          cmd_o.run_clear = 1'b1;
          cmd_o.slot_inc = 1'b1;
          state_d = StIdle;
        end else if (status_i.is_ln) begin
          priority if (status_i.ord_bad) begin
            cmd_o.run_clear = 1'b1;
            cmd_o.slot_inc = 1'b1;
            state_d = StIdle;
          end else if (status_i.last_flag) begin
            cmd_o.run_start = 1'b1;
            cmd_o.wr_init = 1'b1;
            state_d = StWrite;
          end else if (!status_i.run_active || !status_i.chk_match) begin
            cmd_o.run_clear = 1'b1;
            cmd_o.slot_inc = 1'b1;
            state_d = StIdle;
          end else begin
            cmd_o.wr_init = 1'b1;
            state_d = StWrite;
          end
        end else if (status_i.is_vol) begin
          cmd_o.run_clear = 1'b1;
          cmd_o.slot_inc = 1'b1;
          state_d = StIdle;
        end else if (status_i.run_active && status_i.sum_match) begin
          cmd_o.scan_init = 1'b1;
          state_d = StScanWait;
        end else begin
          cmd_o.short_init = 1'b1;
          state_d = StShortLoad;
        end
      end
      StWrite: begin
        cmd_o.wr_unit = 1'b1;
        if (status_i.wr_last) begin
          cmd_o.slot_inc = 1'b1;
          state_d = StIdle;
        end
      end
      StScanWait: begin
        if (status_i.at_max) begin
          fin_scan = 1'b1;
        end else begin
          state_d = StScanChk;
        end
      end
      StScanChk: begin
        priority if (status_i.unit_term) begin
          fin_scan = 1'b1;
        end else if (status_i.addr_at_top) begin
          cmd_o.short_init = 1'b1;
          state_d = StShortLoad;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d = StScanWait;
        end
      end
      StLongWait: begin
        state_d = StLongAcc;
      end
      StLongAcc: begin
        cmd_o.acc_unit = 1'b1;
        state_d = status_i.acc_full ? StLongLoad : StLongWait;
      end
      StLongLoad: begin
        if (status_i.out_free) begin
          cmd_o.load_long = 1'b1;
          if (status_i.long_last) begin
            cmd_o.run_clear = 1'b1;
            cmd_o.slot_inc = 1'b1;
            state_d = StIdle;
          end else begin
            state_d = StLongWait;
          end
        end
      end
      StShortLoad: begin
        if (status_i.out_free) begin
          cmd_o.load_short = 1'b1;
          if (status_i.short_last) begin
            cmd_o.run_clear = 1'b1;
            cmd_o.slot_inc = 1'b1;
            state_d = StIdle;
          end
        end
      end
      StEnd: begin
        if (status_i.out_free) begin
          cmd_o.load_end = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    // scan finished: empty name falls back to the 8.3 name
    if (fin_scan) begin
      if (status_i.addr_zero) begin
        cmd_o.short_init = 1'b1;
        state_d = StShortLoad;
      end else begin
        cmd_o.long_init = 1'b1;
        state_d = StLongWait;
      end
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/fat_directory_entry_walker_core.sv @@
// top level of the fat directory entry walker
`default_nettype none
// Takes a FAT directory one byte per transaction, 32 bytes per slot, and
// emits one result per four name units of each short entry, the last one
// carrying the entry's fields. Bytes are taken one per cycle; after the
// 32nd byte the controller works on the slot with input held off: it
// classifies deleted, label and bad slots, writes a long-name member into
// the name store one unit at a time, loads one result at a time for an 8.3
// name, and for a long name measures it and then streams it out of the
// registered-read name store, which is what sets the rate of long-name
// entries. The result register lets the next slot's bytes be taken while a
// final result waits.
module fat_directory_entry_walker_core #(
  parameter int unsigned MAX_NAME_MEMBERS = 20,
  parameter int unsigned SLOT_INDEX_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        directory_start_i,
  input  wire logic        chain_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      name_chunk_o,
  output logic [2:0]       chunk_units_o,
  output logic             last_of_entry_o,
  output logic             end_of_directory_o,
  output logic [15:0]      entry_slot_o,
  output logic [15:0]      name_start_slot_o,
  output logic [7:0]       attributes_o,
  output logic [31:0]      first_cluster_o,
  output logic [31:0]      file_size_o,
  output logic             used_long_name_o
);

  fat_dew_pkg::cmd_t    cmd;
  fat_dew_pkg::status_t status;

  // controller
  fat_dew_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .directory_start_i(directory_start_i),
    .chain_end_i      (chain_end_i),
    .in_ready_o       (in_ready_o),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  // datapath
  fat_dew_datapath #(
    .MAX_NAME_MEMBERS(MAX_NAME_MEMBERS),
    .SLOT_INDEX_BITS (SLOT_INDEX_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .data_byte_i       (data_byte_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .name_chunk_o      (name_chunk_o),
    .chunk_units_o     (chunk_units_o),
    .last_of_entry_o   (last_of_entry_o),
    .end_of_directory_o(end_of_directory_o),
    .entry_slot_o      (entry_slot_o),
    .name_start_slot_o (name_start_slot_o),
    .attributes_o      (attributes_o),
    .first_cluster_o   (first_cluster_o),
    .file_size_o       (file_size_o),
    .used_long_name_o  (used_long_name_o)
  );

  // an end-of-directory transaction closes its group and carries no name
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_directory_o |-> last_of_entry_o && chunk_units_o == 3'd0)
    else $error("end result malformed");

  // only the final result of an entry may carry fewer than four units
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_entry_o |-> chunk_units_o == 3'd4)
    else $error("short chunk before end of entry");

  // a long name always delivers at least one unit in its final chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && used_long_name_o |-> chunk_units_o != 3'd0 && last_of_entry_o)
    else $error("long name result without units");

  // input is held off while a slot is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !chain_end_i && !directory_start_i &&
    !status.done && status.pos_last |=> !in_ready_o)
    else $error("input taken during slot processing");

endmodule
`default_nettype wire

@@ test/fat_dew_checker.sv @@
// transaction monitor, entry predictor and result comparison for the directory walker
`timescale 1ns / 1ps
module fat_dew_checker
  import fat_dew_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        directory_start_i,
  input  wire logic        chain_end_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [63:0] name_chunk_i,
  input  wire logic [2:0]  chunk_units_i,
  input  wire logic        last_of_entry_i,
  input  wire logic        end_of_directory_i,
  input  wire logic [15:0] entry_slot_i,
  input  wire logic [15:0] name_start_slot_i,
  input  wire logic [7:0]  attributes_i,
  input  wire logic [31:0] first_cluster_i,
  input  wire logic [31:0] file_size_i,
  input  wire logic        used_long_name_i,
  output int               fail_count_o,
  output int               outstanding_o
);

  localparam int MaxMembers = 20;
  localparam int StoreDepth = 260;

  typedef struct packed {
    logic [63:0] chunk;
    logic [2:0]  units;
    logic        last;
    logic        eod;
    logic [15:0] entry_slot;
    logic [15:0] start_slot;
    logic [7:0]  attr;
    logic [31:0] cluster;
    logic [31:0] size;
    logic        used_long;
  } entry_result_t;

  entry_result_t expected_q[$];

  // predictor state
  logic [7:0]  slot_buf [32];
  logic [15:0] name_store [StoreDepth];
  logic [15:0] slot_count;
  int          byte_pos;
  int          run_top;
  logic [7:0]  run_chk;
  logic [15:0] run_first;
  bit          walk_over;

  assign outstanding_o = expected_q.size();

  function automatic logic [15:0] rd16(int off);
    return {slot_buf[(off + 1) % 32], slot_buf[off % 32]};
  endfunction

  function automatic logic [7:0] short_sum();
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < 11; i++) s = {s[0], s[7:1]} + slot_buf[i];
    return s;
  endfunction

  task automatic push_end();
    entry_result_t r;
    r = '0;
    r.last = 1'b1;
    r.eod = 1'b1;
    expected_q.push_back(r);
  endtask

  // name of a short entry, long name when the run is valid
  task automatic predict_short();
    logic [15:0]   nm [StoreDepth];
    int            n;
    int            mx;
    int            cnt;
    int            u;
    bit            use_long;
    logic [63:0]   ch;
    entry_result_t r;
    n = 0;
    use_long = 0;
    if (run_top > 0 && short_sum() == run_chk) begin
      mx = run_top * UnitsPerMember;
      if (mx > StoreDepth) mx = StoreDepth;
      while (n < mx && name_store[n] != 16'h0000 && name_store[n] != UnitPad) n++;
      if (n >= 1 && n <= LongNameMax) begin
        use_long = 1;
        for (int i = 0; i < n; i++) nm[i] = name_store[i];
      end
    end
    if (!use_long) begin
      n = 0;
      for (int i = 0; i < 8 && slot_buf[i] != CharSpace; i++) begin
        nm[n] = (i == 0 && slot_buf[0] == B0Kanji) ? 16'h00E5 : {8'h00, slot_buf[i]};
        n++;
      end
      if (slot_buf[8] != CharSpace) begin
        nm[n] = {8'h00, CharDot};
        n++;
        for (int i = 8; i < 11 && slot_buf[i] != CharSpace; i++) begin
          nm[n] = {8'h00, slot_buf[i]};
          n++;
        end
      end
    end
    cnt = (n + 3) / 4;
    if (cnt == 0) cnt = 1;
    for (int k = 0; k < cnt; k++) begin
      r = '0;
      ch = '0;
      u = 0;
      while (u < 4 && k * 4 + u < n) begin
        ch = ch | ({48'h0, nm[k * 4 + u]} << (16 * u));
        u++;
      end
      r.chunk = ch;
      r.units = u[2:0];
      if (k + 1 == cnt) begin
        r.last = 1'b1;
        r.entry_slot = slot_count;
        r.start_slot = use_long ? run_first : slot_count;
        r.attr = slot_buf[11];
        r.cluster = {rd16(20), rd16(26)};
        r.size = {rd16(30), rd16(28)};
        r.used_long = use_long;
      end
      expected_q.push_back(r);
    end
  endtask

  // classify a complete slot
  task automatic predict_slot();
    logic [7:0] b0;
    logic [7:0] attr;
    int         ord;
    int         base;
    int         off;
    b0 = slot_buf[0];
    attr = slot_buf[11];
    if (b0 == B0Terminator) begin
      push_end();
      walk_over = 1;
      run_top = 0;
      return;
    end
    if (b0 == B0Deleted) begin
      run_top = 0;
    end else if ((attr & OrdMask) == LnAttr) begin
      ord = int'(b0 & OrdMask);
      if (ord == 0 || ord > MaxMembers) begin
        run_top = 0;
      end else begin
        if ((b0 & LastFlag) != 0) begin
          run_top = ord;
          run_chk = slot_buf[13];
          run_first = slot_count;
          for (int i = 0; i < StoreDepth; i++) name_store[i] = 16'h0000;
        end else if (run_top == 0 || slot_buf[13] != run_chk) begin
          run_top = 0;
        end
        if (run_top > 0) begin
          base = (ord - 1) * UnitsPerMember;
          for (int i = 0; i < 13; i++) begin
            off = i < 5 ? 1 + i * 2 : (i < 11 ? 14 + (i - 5) * 2 : 28 + (i - 11) * 2);
            if (base + i < StoreDepth) name_store[base + i] = rd16(off);
          end
        end
      end
    end else if ((attr & VolBit) != 0) begin
      run_top = 0;
    end else begin
      predict_short();
      run_top = 0;
    end
    slot_count = slot_count + 16'd1;
  endtask

  task automatic predict_byte(logic [7:0] d, logic st, logic ce);
    if (st) begin
      slot_count = '0;
      byte_pos = 0;
      run_top = 0;
      walk_over = 0;
    end
    if (walk_over) return;
    if (ce) begin
      push_end();
      walk_over = 1;
      run_top = 0;
      byte_pos = 0;
      return;
    end
    slot_buf[byte_pos] = d;
    if (byte_pos < 31) begin
      byte_pos++;
      return;
    end
    byte_pos = 0;
    predict_slot();
  endtask

  task automatic check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %0h actual %0h", $realtime, fname, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // compare results first, then predict from the accepted byte
  always @(posedge clk_i or negedge rst_ni) begin
    entry_result_t e;
    if (!rst_ni) begin
      expected_q.delete();
      fail_count_o = 0;
      slot_count = '0;
      byte_pos = 0;
      run_top = 0;
      run_chk = '0;
      run_first = '0;
      walk_over = 0;
      for (int i = 0; i < 32; i++) slot_buf[i] = '0;
      for (int i = 0; i < StoreDepth; i++) name_store[i] = '0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result transaction chunk %0h", $realtime, name_chunk_i);
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          check_field("name_chunk", e.chunk, name_chunk_i);
          check_field("chunk_units", e.units, chunk_units_i);
          check_field("last_of_entry", e.last, last_of_entry_i);
          check_field("end_of_directory", e.eod, end_of_directory_i);
          check_field("entry_slot", e.entry_slot, entry_slot_i);
          check_field("name_start_slot", e.start_slot, name_start_slot_i);
          check_field("attributes", e.attr, attributes_i);
          check_field("first_cluster", e.cluster, first_cluster_i);
          check_field("file_size", e.size, file_size_i);
          check_field("used_long_name", e.used_long, used_long_name_i);
        end
      end
      if (in_valid_i && in_ready_i) predict_byte(data_byte_i, directory_start_i, chain_end_i);
    end
  end

endmodule

@@ test/fat_directory_entry_walker_core_tb.sv @@
// stimulus and verdict for the fat directory entry walker
`timescale 1ns / 1ps
module fat_directory_entry_walker_core_tb;
  import fat_dew_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int ByteTarget = 350;
  localparam int ResultTarget = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        directory_start_i;
  logic        chain_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] name_chunk_o;
  logic [2:0]  chunk_units_o;
  logic        last_of_entry_o;
  logic        end_of_directory_o;
  logic [15:0] entry_slot_o;
  logic [15:0] name_start_slot_o;
  logic [7:0]  attributes_o;
  logic [31:0] first_cluster_o;
  logic [31:0] file_size_o;
  logic        used_long_name_o;
  int          fail_count;
  int          outstanding;

  int          cycles;
  int          bytes_sent;
  int          results_seen;
  bit          hold_req;
  bit          calm_in;
  logic [7:0]  slot_buf [32];
  logic [7:0]  short_buf [32];
  logic [15:0] units [260];

  fat_directory_entry_walker_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .directory_start_i,
    .chain_end_i, .out_valid_o, .out_ready_i, .name_chunk_o, .chunk_units_o,
    .last_of_entry_o, .end_of_directory_o, .entry_slot_o, .name_start_slot_o,
    .attributes_o, .first_cluster_o, .file_size_o, .used_long_name_o
  );

  fat_dew_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .data_byte_i,
    .directory_start_i, .chain_end_i, .out_valid_i(out_valid_o), .out_ready_i,
    .name_chunk_i(name_chunk_o), .chunk_units_i(chunk_units_o),
    .last_of_entry_i(last_of_entry_o), .end_of_directory_i(end_of_directory_o),
    .entry_slot_i(entry_slot_o), .name_start_slot_i(name_start_slot_o),
    .attributes_i(attributes_o), .first_cluster_i(first_cluster_o),
    .file_size_i(file_size_o), .used_long_name_i(used_long_name_o),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog and result count
  always @(posedge clk_i) begin
    cycles++;
    if (out_valid_o && out_ready_i) results_seen++;
    if (cycles > CycleLimit) begin
      $display("fat_directory_entry_walker_core_tb failed");
      $finish;
    end
  end

  // receiver: random stalls, calm stretches, and the long hold-off on request
  initial begin
    bit busy;
    busy = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (2000) @(negedge clk_i);
        hold_req = 0;
      end else begin
        if ($urandom_range(0, 99) < 3) busy = ~busy;
        if ($urandom_range(0, 999) < 2) begin
          out_ready_i = 1'b0;
          repeat ($urandom_range(20, 80)) @(negedge clk_i);
        end
        out_ready_i = busy ? ($urandom_range(0, 9) < 6) : 1'b1;
      end
    end
  end

  function automatic int next_gap();
    int r;
    if ($urandom_range(0, 99) < 3) calm_in = ~calm_in;
    if (calm_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one byte transaction, valid held until accepted
  task automatic send_byte(logic [7:0] d, logic st, logic ce);
    int g;
    in_valid_i = 1'b1;
    data_byte_i = d;
    directory_start_i = st;
    chain_end_i = ce;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
    g = next_gap();
    if (g > 0) begin
      in_valid_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic send_slot(logic st);
    for (int i = 0; i < 32; i++) send_byte(slot_buf[i], (i == 0) ? st : 1'b0, 1'b0);
  endtask

  // sender pause until every expected result has come
  task automatic drain();
    in_valid_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] short_checksum();
    logic [7:0] s;
    s = 8'h00;
    for (int i = 0; i < 11; i++) s = {s[0], s[7:1]} + short_buf[i];
    return s;
  endfunction

  function automatic logic [7:0] name_char();
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  // short entry: flavor 0 normal, 1 empty name, 2 kanji lead, 3 all ones fields
  task automatic build_short(int flavor);
    int nl;
    int el;
    for (int i = 0; i < 32; i++) short_buf[i] = 8'($urandom_range(0, 255));
    nl = $urandom_range(1, 8);
    el = $urandom_range(0, 3);
    for (int i = 0; i < 8; i++) short_buf[i] = (i < nl) ? name_char() : CharSpace;
    for (int i = 0; i < 3; i++) short_buf[8 + i] = (i < el) ? name_char() : CharSpace;
    if (flavor == 1) for (int i = 0; i < 11; i++) short_buf[i] = CharSpace;
    if (flavor == 2) short_buf[0] = B0Kanji;
    case ($urandom_range(0, 3))
      0: short_buf[11] = 8'h00;
      1: short_buf[11] = 8'h10;
      default: short_buf[11] = 8'($urandom_range(0, 255)) & ~VolBit;
    endcase
    if (flavor == 3) begin
      for (int i = 12; i < 32; i++) short_buf[i] = 8'hFF;
      short_buf[11] = 8'hF7;
    end
  endtask

  task automatic send_short(logic st);
    for (int i = 0; i < 32; i++) slot_buf[i] = short_buf[i];
    send_slot(st);
  endtask

  // long-name run of len units for short_buf, optionally with a bad checksum
  task automatic send_long(int len, bit bad_chk, logic st);
    int         m;
    int         base;
    int         off;
    logic [7:0] chk;
    m = (len + 12) / 13;
    if (m > 20) m = 20;
    chk = short_checksum();
    for (int i = 0; i < 260; i++)
      units[i] = (i < len) ? (($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 16'hFFFE))
                 : {8'h00, name_char()}) : ((i == len) ? 16'h0000 : UnitPad);
    if (len > 2 && $urandom_range(0, 9) == 0) units[$urandom_range(1, len - 1)] = 16'h0000;
    for (int mi = m; mi >= 1; mi--) begin
      for (int i = 0; i < 32; i++) slot_buf[i] = 8'($urandom_range(0, 255));
      slot_buf[0] = 8'(mi) | ((mi == m) ? LastFlag : 8'h00);
      slot_buf[11] = ($urandom_range(0, 3) == 0) ? (LnAttr | 8'hC0) : LnAttr;
      slot_buf[12] = 8'h00;
      slot_buf[13] = (bad_chk && mi == 1) ? (chk ^ 8'h5A) : chk;
      slot_buf[26] = 8'h00;
      slot_buf[27] = 8'h00;
      base = (mi - 1) * 13;
      for (int i = 0; i < 13; i++) begin
        off = i < 5 ? 1 + i * 2 : (i < 11 ? 14 + (i - 5) * 2 : 28 + (i - 11) * 2);
        slot_buf[off] = units[base + i][7:0];
        slot_buf[off + 1] = units[base + i][15:8];
      end
      send_slot((mi == m) ? st : 1'b0);
    end
  endtask

  // noise slot: 0 deleted, 1 volume label, 2 bad ordinal, 3 orphan member, 4 random
  task automatic send_noise(int kind, logic st);
    for (int i = 0; i < 32; i++) slot_buf[i] = 8'($urandom_range(0, 255));
    case (kind)
      0: slot_buf[0] = B0Deleted;
      1: begin
        slot_buf[0] = name_char();
        slot_buf[11] = VolBit | 8'($urandom_range(0, 3));
      end
      2: begin
        slot_buf[0] = ($urandom_range(0, 1) == 0) ? LastFlag : 8'($urandom_range(21, 63));
        slot_buf[11] = LnAttr;
      end
      3: begin
        slot_buf[0] = 8'($urandom_range(1, 20));
        slot_buf[11] = LnAttr;
      end
      default: if (slot_buf[0] == B0Terminator) slot_buf[0] = 8'h01;
    endcase
    send_slot(st);
  endtask

  task automatic send_terminator();
    for (int i = 0; i < 32; i++) slot_buf[i] = 8'($urandom_range(0, 255));
    slot_buf[0] = B0Terminator;
    send_slot(1'b0);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom_range(240, 260);
    if (r < 80) return $urandom_range(1, 20);
    return $urandom_range(21, 60);
  endfunction

  // well-formed directory with random content and some noise
  task automatic random_directory();
    int  n;
    int  k;
    bit  first;
    first = 1;
    n = $urandom_range(1, 5);
    for (int e = 0; e < n; e++) begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        build_short($urandom_range(0, 9) == 0 ? 2 : 0);
        send_long(pick_len(), $urandom_range(0, 9) == 0, first);
        send_short(1'b0);
      end else if (k < 80) begin
        build_short($urandom_range(0, 19) == 0 ? 1 : 0);
        send_short(first);
      end else begin
        send_noise($urandom_range(0, 4), first);
      end
      first = 0;
    end
    k = $urandom_range(0, 9);
    if (k < 6) begin
      send_terminator();
    end else if (k < 8) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else if (k < 9) begin
      repeat ($urandom_range(1, 31)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else begin
      // abandoned mid-slot, the next directory restarts the walk
      repeat ($urandom_range(1, 31)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
  endtask

  initial begin
    cycles = 0;
    bytes_sent = 0;
    results_seen = 0;
    hold_req = 0;
    calm_in = 0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    directory_start_i = 1'b0;
    chain_end_i = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: plain, kanji, empty, all-ones fields, long names and their fallbacks
    build_short(0);
    send_short(1'b1);
    build_short(2);
    send_short(1'b0);
    build_short(1);
    send_short(1'b0);
    build_short(3);
    send_short(1'b0);
    build_short(0);
    send_long(13, 0, 1'b0);
    send_short(1'b0);
    build_short(0);
    send_long(7, 1, 1'b0);
    send_short(1'b0);
    build_short(0);
    send_long(255, 0, 1'b0);
    send_short(1'b0);
    build_short(0);
    send_long(258, 0, 1'b0);
    send_short(1'b0);
    for (int kind = 0; kind < 5; kind++) send_noise(kind, 1'b0);
    build_short(0);
    send_short(1'b0);
    send_terminator();
    // bytes and chain ends after the end are ignored
    send_noise(4, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    // start and chain end together
    send_byte(8'hFF, 1'b1, 1'b1);
    // partial slot at chain end, then restart mid-slot
    build_short(0);
    send_short(1'b1);
    repeat (10) send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    repeat (5) send_byte(8'h3C, 1'b1, 1'b0);
    build_short(0);
    send_short(1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    drain();

    // receiver holds off while the sender keeps pushing
    hold_req = 1;
    build_short(0);
    send_long(40, 0, 1'b1);
    send_short(1'b0);
    for (int i = 0; i < 4; i++) begin
      build_short(0);
      send_short(1'b0);
    end
    send_terminator();

    // random directories
    while (bytes_sent < ByteTarget || results_seen < ResultTarget) begin
      random_directory();
      if ($urandom_range(0, 4) == 0) drain();
    end

    drain();
    repeat (300) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("fat_directory_entry_walker_core_tb passed");
    end else begin
      $display("fat_directory_entry_walker_core_tb failed");
    end
    $finish;
  end

endmodule
